@@ rtl/core/grid_min_path_sum_query_unit_assert.svh @@
// Assertion macros for the grid minimum path sum query unit.
// Included by the top level; needs clk and rst_n in scope.
`ifndef GRID_MIN_PATH_SUM_QUERY_UNIT_ASSERT_SVH
`define GRID_MIN_PATH_SUM_QUERY_UNIT_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define GMP_ASSERT_IMPL(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication outside reset.
`define GMP_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

@@ rtl/core/gmpq_pkg.sv @@
// Package for the grid minimum path sum query unit.
// Holds payload structs, the state enum and sizing constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gmpq_pkg;
  localparam int GRID_SIDE_DEF   = 256;
  localparam int WEIGHT_BITS_DEF = 32;
  localparam int SUM_BITS        = 48;
  localparam int IDX_BITS        = 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_BOUNDS = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic [IDX_BITS-1:0]        cell_row;
    logic [IDX_BITS-1:0]        cell_col;
    logic signed [31:0]         cell_weight;
    logic [IDX_BITS-1:0]        rect_top;
    logic [IDX_BITS-1:0]        rect_bottom;
    logic [IDX_BITS-1:0]        rect_left;
    logic [IDX_BITS-1:0]        rect_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [SUM_BITS-1:0] path_sum;
    logic                       status;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_WAIT, S_STEP, S_DRAIN, S_OUT
  } state_t;

  // Control shared by the cell chain.
  typedef struct packed {
    logic shift;      // advance the chain one column
    logic first_row;  // top row: no value from above
    logic first_col;  // leftmost column: no value from the left
  } chain_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/gmpq_cell.sv @@
// One DP cell: holds the partial sum of one column of the row buffer.
// Depends on gmpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gmpq_cell (
  input  wire logic                                clk,
  input  wire logic                                shift,
  input  wire logic signed [gmpq_pkg::SUM_BITS-1:0] din,
  output logic signed [gmpq_pkg::SUM_BITS-1:0]      dout
);
  logic signed [gmpq_pkg::SUM_BITS-1:0] val_r;
  always_ff @(posedge clk) begin
    if (shift) begin
      val_r <= din;
    end
  end
  assign dout = val_r;
endmodule
`default_nettype wire

@@ rtl/core/gmpq_chain.sv @@
// Row buffer as a shift chain of cells plus the min-add head.
// Depends on gmpq_pkg and gmpq_cell.
`timescale 1ns / 1ps
`default_nettype none
module gmpq_chain #(
  parameter int GRID_SIDE = gmpq_pkg::GRID_SIDE_DEF,
  parameter int WEIGHT_BITS = gmpq_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire gmpq_pkg::chain_ctl_t                 ctl,
  input  wire logic signed [WEIGHT_BITS-1:0]        weight,
  output logic signed [gmpq_pkg::SUM_BITS-1:0]      last_sum
);
  localparam int SB = gmpq_pkg::SUM_BITS;
  logic signed [SB-1:0] link [GRID_SIDE+1];
  logic signed [SB-1:0] up, best, head;

  // The cell next to the head holds this row's previous column (left);
  // the chain tail holds the same column from the row above, GRID_SIDE
  // shifts back.
  genvar g;
  generate
    for (g = 0; g < GRID_SIDE; g++) begin : g_cell
      gmpq_cell u_cell (.clk(clk), .shift(ctl.shift), .din(link[g]), .dout(link[g+1]));
    end
  endgenerate

  assign up = link[GRID_SIDE];
  always_comb begin
    if (ctl.first_row && ctl.first_col) best = '0;
    else if (ctl.first_row) best = link[1];
    else if (ctl.first_col) best = up;
    else best = (up < link[1]) ? up : link[1];
    head = best + SB'(weight);
  end
  assign link[0]  = head;
  assign last_sum = link[1];
endmodule
`default_nettype wire

@@ rtl/core/grid_min_path_sum_query_unit.sv @@
// Top level of the grid minimum path sum query unit.
// Depends on gmpq_pkg, gmpq_chain and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
// A query over an R x C rectangle walks it row by row and rotates the chain
// after every row but the last: one grid memory read per cell feeds a chain
// of GRID_SIDE cells that shifts once per cell, and each column has to come
// round to the chain tail before the next row reads it. An inverted-bounds
// query goes straight from idle to its bounds result.
// One item is in work at a time; a finished query holds in its last state
// while an earlier result still waits on the output, and loads are taken
// while a result waits.
`include "grid_min_path_sum_query_unit_assert.svh"
module grid_min_path_sum_query_unit #(
  parameter int GRID_SIDE = gmpq_pkg::GRID_SIDE_DEF,
  parameter int WEIGHT_BITS = gmpq_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gmpq_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gmpq_pkg::out_beat_t      out_data
);
  localparam int IB = gmpq_pkg::IDX_BITS;
  localparam int AB = $clog2(GRID_SIDE);
  localparam int SB = gmpq_pkg::SUM_BITS;
  localparam int MEM_DEPTH = 1 << (2 * AB);

  logic signed [WEIGHT_BITS-1:0] mem [MEM_DEPTH];
  logic signed [WEIGHT_BITS-1:0] rd_r;

  gmpq_pkg::state_t state_r, state_nxt;
  logic [AB-1:0] top_r, bot_r, lft_r, rgt_r, row_r, col_r;
  logic [AB-1:0] top_n, bot_n, lft_n, rgt_n, row_n, col_n;
  logic [AB:0]   pos_r, pos_n;  // chain position, counts to GRID_SIDE
  logic          ovalid_r, ovalid_nxt;
  gmpq_pkg::out_beat_t obeat_r, obeat_nxt;
  gmpq_pkg::chain_ctl_t ctl;
  logic signed [SB-1:0] last_sum;
  logic          rd_en, wr_en;
  logic [2*AB-1:0] rd_addr;

  function automatic logic [AB-1:0] clampi(input logic [IB-1:0] v);
    if ({{(AB+1){1'b0}}, v} > (AB+IB+1)'(GRID_SIDE-1)) return AB'(GRID_SIDE-1);
    return AB'(v);
  endfunction

  assign wr_en = in_valid && in_ready && (in_data.opcode == gmpq_pkg::OP_LOAD)
    && ({{AB{1'b0}}, in_data.cell_row} < (AB+IB)'(GRID_SIDE))
    && ({{AB{1'b0}}, in_data.cell_col} < (AB+IB)'(GRID_SIDE));

  always_ff @(posedge clk) begin
    if (wr_en) mem[{AB'(in_data.cell_row), AB'(in_data.cell_col)}] <= in_data.cell_weight[WEIGHT_BITS-1:0];
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmpq_pkg::S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    top_r <= top_n; bot_r <= bot_n; lft_r <= lft_n; rgt_r <= rgt_n;
    row_r <= row_n; col_r <= col_n; pos_r <= pos_n; obeat_r <= obeat_nxt;
  end

  // Sequencer: walk the rectangle row by row. After each row but the last,
  // rotate the chain so column lft sits again at the tap that feeds the head.
  always_comb begin
    state_nxt = state_r;
    top_n = top_r; bot_n = bot_r; lft_n = lft_r; rgt_n = rgt_r;
    row_n = row_r; col_n = col_r; pos_n = pos_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obeat_nxt = obeat_r;
    in_ready = 1'b0;
    rd_en = 1'b0;
    rd_addr = {row_r, col_r};
    ctl = '0;
    ctl.first_row = (row_r == top_r);
    ctl.first_col = (col_r == lft_r);
    case (state_r)
      gmpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.opcode == gmpq_pkg::OP_QUERY) begin
          top_n = clampi(in_data.rect_top);
          bot_n = clampi(in_data.rect_bottom);
          lft_n = clampi(in_data.rect_left);
          rgt_n = clampi(in_data.rect_right);
          row_n = top_n; col_n = lft_n;
          if (top_n > bot_n || lft_n > rgt_n) begin
            state_nxt = gmpq_pkg::S_OUT;
          end else begin
            state_nxt = gmpq_pkg::S_FETCH;
          end
        end
      end
      gmpq_pkg::S_FETCH: begin
        rd_en = 1'b1;
        state_nxt = gmpq_pkg::S_STEP;
      end
      gmpq_pkg::S_STEP: begin
        ctl.shift = 1'b1;
        if (col_r == rgt_r) begin
          col_n = lft_r;
          if (row_r == bot_r) begin
            state_nxt = gmpq_pkg::S_WAIT;
          end else begin
            pos_n = (AB+1)'(rgt_r - lft_r) + (AB+1)'(1);
            state_nxt = gmpq_pkg::S_DRAIN;
          end
        end else begin
          col_n = col_r + AB'(1);
          rd_addr = {row_r, col_n};
          rd_en = 1'b1;
        end
      end
      gmpq_pkg::S_DRAIN: begin
        // Rotate the rest of the ring; values pass through the head as copies
        // of the cell next to the head, so use the plain-pass setting.
        ctl.shift = 1'b1;
        ctl.first_row = 1'b1;
        ctl.first_col = 1'b0;
        rd_addr = {row_r + AB'(1), lft_r};
        if (pos_r == (AB+1)'(GRID_SIDE)) begin
          ctl.shift = 1'b0;
          row_n = row_r + AB'(1);
          rd_en = 1'b1;
          state_nxt = gmpq_pkg::S_STEP;
        end else begin
          pos_n = pos_r + (AB+1)'(1);
        end
      end
      gmpq_pkg::S_WAIT: begin
        if (!ovalid_r) begin
          obeat_nxt.path_sum = last_sum;
          obeat_nxt.status = gmpq_pkg::ST_OK;
          ovalid_nxt = 1'b1;
          state_nxt = gmpq_pkg::S_IDLE;
        end
      end
      gmpq_pkg::S_OUT: begin
        if (!ovalid_r) begin
          obeat_nxt.path_sum = '0;
          obeat_nxt.status = gmpq_pkg::ST_BOUNDS;
          ovalid_nxt = 1'b1;
          state_nxt = gmpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = gmpq_pkg::S_IDLE;
    endcase
  end

  // In drain, the pass-through must add nothing: weight is forced to zero.
  logic signed [WEIGHT_BITS-1:0] chain_w;
  assign chain_w = (state_r == gmpq_pkg::S_DRAIN) ? '0 : rd_r;

  gmpq_chain #(.GRID_SIDE(GRID_SIDE), .WEIGHT_BITS(WEIGHT_BITS)) u_chain (
    .clk(clk), .ctl(ctl), .weight(chain_w), .last_sum(last_sum)
  );

  assign out_valid = ovalid_r;
  assign out_data  = obeat_r;

  `GMP_ASSERT_IMPL(a_busy_no_ready, state_r != gmpq_pkg::S_IDLE, !in_ready, "ready while busy")
  `GMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `GMP_ASSERT_IMPL(a_err_zero, out_valid && out_data.status == gmpq_pkg::ST_BOUNDS, out_data.path_sum == '0, "error sum nonzero")
endmodule
`default_nettype wire
